FILE: src/assert_macros.svh
// Assertion macros shared by the velocity frame receiver RTL.
// No dependencies; define SYNTH to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// A property that must hold at every clock edge outside of reset.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: property failed");

// A condition that must never be true outside of reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

FILE: src/vfrw_pkg.sv
// Shared constants and types of the velocity frame receiver.
// No dependencies; used by the window, watchdog and top level.
`default_nettype none

package vfrw_pkg;

  // Frame layout constants.
  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;
  localparam logic [7:0] VEL_TYPE    = 8'h01;
  localparam logic [7:0] VEL_LEN     = 8'h04;

  // Window geometry: eight held bytes plus the incoming one make a frame.
  localparam int WIN_DEPTH = 8;
  localparam int WIN_IDX_W = $clog2(WIN_DEPTH);
  localparam int FILL_W    = WIN_IDX_W + 1;
  localparam logic [FILL_W-1:0] WIN_FULL = FILL_W'(WIN_DEPTH);

  // Watchdog limit after reset.
  localparam logic [15:0] WDOG_LIMIT_RST = 16'd50;

  // Input command codes.
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Match result of the window for the current byte.
  typedef struct packed {
    logic        match;
    logic [15:0] left;
    logic [15:0] right;
  } frame_info_t;

  // Watchdog controls for one processed word.
  typedef struct packed {
    logic tick;
    logic clear;
  } wdog_ctrl_t;

endpackage

`default_nettype wire

FILE: src/vfrw_window.sv
// Sliding byte window and velocity frame matcher.
// Depends on vfrw_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module vfrw_window (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 byte_en,
  input  wire logic [7:0]           rx_byte,
  input  wire logic                 chunk_end,
  output vfrw_pkg::frame_info_t     info
);
  import vfrw_pkg::*;

  logic [7:0]        win_r [WIN_DEPTH];
  logic [FILL_W-1:0] fill_r;
  logic              full;
  logic [7:0]        sum;

  // Header and length compare against held bytes, the checksum against the incoming byte.
  always_comb begin
    full = (fill_r == WIN_FULL);
    sum  = VEL_TYPE ^ VEL_LEN ^ win_r[4] ^ win_r[5] ^ win_r[6] ^ win_r[7];
    info.match = full && (win_r[0] == SYNC_FIRST) && (win_r[1] == SYNC_SECOND) &&
                 (win_r[2] == VEL_TYPE) && (win_r[3] == VEL_LEN) && (sum == rx_byte);
    info.left  = {win_r[5], win_r[4]};
    info.right = {win_r[7], win_r[6]};
  end

  // Fill count: empties on a match or at the end of a chunk.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (byte_en) begin
      if (info.match || chunk_end) begin
        fill_r <= '0;
      end else if (!full) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  // Byte storage: append while filling, shift out the oldest when full.
  always_ff @(posedge clk) begin
    if (byte_en && !info.match) begin
      if (full) begin
        for (int k = 0; k < WIN_DEPTH - 1; k++) begin
          win_r[k] <= win_r[k+1];
        end
        win_r[WIN_DEPTH-1] <= rx_byte;
      end else begin
        win_r[fill_r[WIN_IDX_W-1:0]] <= rx_byte;
      end
    end
  end

  `ASSERT_NEVER(a_fill_range, clk, rst_n, fill_r > WIN_FULL)
  `ASSERT_PROP(a_match_empties, clk, rst_n, (byte_en && info.match) |=> (fill_r == '0))
  `ASSERT_PROP(a_match_needs_full, clk, rst_n, info.match |-> full)

endmodule

`default_nettype wire

FILE: src/vfrw_watchdog.sv
// Saturating silence counter that flags expiry of the command watchdog.
// Depends on vfrw_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module vfrw_watchdog (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire vfrw_pkg::wdog_ctrl_t ctrl,
  input  wire logic [15:0]          limit,
  output logic                      expire
);
  import vfrw_pkg::*;

  logic [15:0] count_r;
  logic [15:0] count_inc;
  logic        below;

  // A tick counts only below the limit; reaching it is the expiry.
  always_comb begin
    below     = (count_r < limit);
    count_inc = count_r + 16'd1;
    expire    = ctrl.tick && below && (count_inc == limit);
  end

  // Counter update: a valid frame clears, a tick below the limit advances.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctrl.clear) begin
      count_r <= '0;
    end else if (ctrl.tick && below) begin
      count_r <= count_inc;
    end
  end

  `ASSERT_NEVER(a_tick_and_clear, clk, rst_n, ctrl.tick && ctrl.clear)
  `ASSERT_PROP(a_expire_at_limit, clk, rst_n, expire |=> (count_r == $past(limit)))

endmodule

`default_nettype wire

FILE: src/velocity_frame_receiver_watchdog.sv
// Top level of the velocity frame receiver with command watchdog.
// Depends on vfrw_pkg, vfrw_window, vfrw_watchdog and assert_macros.svh.
//
// Usage: the input channel carries one word per received serial byte
// (command 0, with rx_byte and chunk_end) or per watchdog tick (command 1).
// Every input word produces exactly one output word with the current left
// and right targets in mrad/s, a frame_accepted flag for the byte that
// completed a valid frame, and a stop_event flag for the tick that made the
// watchdog expire. Both channels use valid/stall; a word moves on an edge
// with valid high and stall low.
// A word is captured in the input register, then the frame match and
// watchdog update run in one pass into the output register. The block
// takes one word per cycle unless the receiver stalls; then the output
// register holds its word and in_stall is high while the input register
// holds one. Reset (synchronous, active low) empties the window, zeroes
// both targets and the silence count, and loads a watchdog limit of 50.
// The limit is written through cfg_write_en/cfg_write_data; the user
// writes it only while the block is idle; the block does not enforce it.
`default_nettype none
`include "assert_macros.svh"

module velocity_frame_receiver_watchdog (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // Configuration port
  input  wire logic               cfg_write_en,
  input  wire logic [15:0]        cfg_write_data,
  // Input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_command,
  input  wire logic [7:0]         in_rx_byte,
  input  wire logic               in_chunk_end,
  // Output channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_left_target,
  output logic signed [15:0]      out_right_target,
  output logic                    out_frame_accepted,
  output logic                    out_stop_event
);
  import vfrw_pkg::*;

  logic [15:0] wdog_limit_r;

  logic        s1_valid_r;
  logic        s1_command_r;
  logic [7:0]  s1_byte_r;
  logic        s1_chunk_end_r;

  logic        out_valid_r;
  logic [15:0] out_left_r;
  logic [15:0] out_right_r;
  logic        out_frame_r;
  logic        out_stop_r;

  logic [15:0] left_speed_r;
  logic [15:0] right_speed_r;

  logic          s1_adv;
  logic          step;
  logic          byte_en;
  frame_info_t   info;
  wdog_ctrl_t    wd_ctrl;
  logic          expire;
  logic          accepted;
  logic [15:0]   left_nxt;
  logic [15:0]   right_nxt;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wdog_limit_r <= WDOG_LIMIT_RST;
    end else if (cfg_write_en) begin
      wdog_limit_r <= cfg_write_data;
    end
  end

  // Handshake: the input register moves on whenever the output has room.
  always_comb begin
    s1_adv   = !out_valid_r || !out_stall;
    in_stall = s1_valid_r && !s1_adv;
    step     = s1_valid_r && s1_adv;
    byte_en  = step && (s1_command_r == CMD_BYTE);
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_command_r   <= in_command;
      s1_byte_r      <= in_rx_byte;
      s1_chunk_end_r <= in_chunk_end;
    end
  end

  vfrw_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (byte_en),
    .rx_byte   (s1_byte_r),
    .chunk_end (s1_chunk_end_r),
    .info      (info)
  );

  always_comb begin
    accepted      = byte_en && info.match;
    wd_ctrl.tick  = step && (s1_command_r == CMD_TICK);
    wd_ctrl.clear = accepted;
  end

  vfrw_watchdog u_watchdog (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (wd_ctrl),
    .limit  (wdog_limit_r),
    .expire (expire)
  );

  // Target selection: a frame loads, an expiry zeroes, otherwise hold.
  always_comb begin
    priority if (accepted) begin
      left_nxt  = info.left;
      right_nxt = info.right;
    end else if (expire) begin
      left_nxt  = '0;
      right_nxt = '0;
    end else begin
      left_nxt  = left_speed_r;
      right_nxt = right_speed_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_speed_r  <= '0;
      right_speed_r <= '0;
    end else if (step) begin
      left_speed_r  <= left_nxt;
      right_speed_r <= right_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_left_r  <= left_nxt;
      out_right_r <= right_nxt;
      out_frame_r <= accepted;
      out_stop_r  <= expire;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_left_target    = $signed(out_left_r);
  assign out_right_target   = $signed(out_right_r);
  assign out_frame_accepted = out_frame_r;
  assign out_stop_event     = out_stop_r;

  `ASSERT_NEVER(a_flags_exclusive, clk, rst_n, out_valid_r && out_frame_r && out_stop_r)
  `ASSERT_PROP(a_stop_zeroes, clk, rst_n,
    (out_valid_r && out_stop_r) |-> (out_left_r == '0 && out_right_r == '0))
  `ASSERT_PROP(a_drain, clk, rst_n,
    (out_valid_r && !out_stall && !s1_valid_r) |=> !out_valid_r)
  `ASSERT_PROP(a_cfg_write, clk, rst_n,
    $past(cfg_write_en) |-> (wdog_limit_r == $past(cfg_write_data)))

endmodule

`default_nettype wire

FILE: dv/vfrw_target_checker.sv
`timescale 1ns / 1ps
// Checker for velocity_frame_receiver_watchdog: follows the watchdog limit register and
// predicts each output word from the accepted input words, then compares them in order.
// Depends on vfrw_pkg for the frame constants and the command codes.
module vfrw_target_checker
  import vfrw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_write_en,
  input  logic [15:0]        cfg_write_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_command,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_chunk_end,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_left_target,
  input  logic signed [15:0] out_right_target,
  input  logic               out_frame_accepted,
  input  logic               out_stop_event,
  output int unsigned        fail_count,
  output int unsigned        pending_words,
  output int unsigned        words_checked,
  output int unsigned        frames_seen,
  output int unsigned        stops_seen
);

  // One output word as the block should produce it.
  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               accepted;
    logic               stop;
  } target_word_t;

  // Mirror of the block's state.
  logic [7:0]         held_bytes [WIN_DEPTH];
  logic [FILL_W-1:0]  held_count;
  logic signed [15:0] left_now;
  logic signed [15:0] right_now;
  logic [15:0]        silent_ticks;
  logic [15:0]        tick_limit;
  target_word_t       expected_targets [$];

  // Advances the mirrored state by one input word and returns the word it causes.
  function automatic target_word_t next_targets(input logic cmd, input logic [7:0] rx,
                                                input logic ce);
    target_word_t w;
    logic [7:0]   xsum;
    logic         hit;
    w.accepted = 1'b0;
    w.stop     = 1'b0;
    if (cmd == CMD_TICK) begin
      // The watchdog saturates at the limit; only the tick that reaches it stops.
      if (silent_ticks < tick_limit) begin
        silent_ticks = silent_ticks + 16'd1;
        if (silent_ticks == tick_limit) begin
          left_now  = '0;
          right_now = '0;
          w.stop    = 1'b1;
        end
      end
    end else begin
      // Bytes 4 to 7 of the window hold the two little-endian speeds.
      xsum = VEL_TYPE ^ VEL_LEN ^ held_bytes[4] ^ held_bytes[5] ^ held_bytes[6] ^ held_bytes[7];
      hit  = (held_count == WIN_FULL) && (held_bytes[0] == SYNC_FIRST) &&
             (held_bytes[1] == SYNC_SECOND) && (held_bytes[2] == VEL_TYPE) &&
             (held_bytes[3] == VEL_LEN) && (xsum == rx);
      if (hit) begin
        left_now     = {held_bytes[5], held_bytes[4]};
        right_now    = {held_bytes[7], held_bytes[6]};
        silent_ticks = '0;
        held_count   = '0;
        w.accepted   = 1'b1;
      end else if (held_count < WIN_FULL) begin
        held_bytes[held_count[WIN_IDX_W-1:0]] = rx;
        held_count = held_count + 1'b1;
      end else begin
        // A full window slides by one byte so every offset gets tried.
        for (int k = 0; k < WIN_DEPTH - 1; k++) held_bytes[k] = held_bytes[k + 1];
        held_bytes[WIN_DEPTH - 1] = rx;
      end
      if (ce) held_count = '0;
    end
    w.left  = left_now;
    w.right = right_now;
    return w;
  endfunction

  // Watch both channels and the register port at every rising edge.
  always @(posedge clk) begin : watch_channels
    target_word_t want;
    if (!rst_n) begin
      for (int k = 0; k < WIN_DEPTH; k++) held_bytes[k] = '0;
      held_count    = '0;
      left_now      = '0;
      right_now     = '0;
      silent_ticks  = '0;
      tick_limit    = WDOG_LIMIT_RST;
      expected_targets.delete();
      fail_count    = 0;
      words_checked = 0;
      frames_seen   = 0;
      stops_seen    = 0;
    end else begin
      if (cfg_write_en) tick_limit = cfg_write_data;
      if (in_valid && !in_stall)
        expected_targets.push_back(next_targets(in_command, in_rx_byte, in_chunk_end));
      if (out_valid && !out_stall) begin
        if (expected_targets.size() == 0) begin
          $error("unexpected output word: left_target %0d, right_target %0d",
                 out_left_target, out_right_target);
          fail_count++;
        end else begin
          want = expected_targets.pop_front();
          words_checked++;
          if (out_frame_accepted === 1'b1) frames_seen++;
          if (out_stop_event === 1'b1) stops_seen++;
          if (out_left_target !== want.left) begin
            $error("left_target: expected %0d, actual %0d", want.left, out_left_target);
            fail_count++;
          end
          if (out_right_target !== want.right) begin
            $error("right_target: expected %0d, actual %0d", want.right, out_right_target);
            fail_count++;
          end
          if (out_frame_accepted !== want.accepted) begin
            $error("frame_accepted: expected %0d, actual %0d", want.accepted,
                   out_frame_accepted);
            fail_count++;
          end
          if (out_stop_event !== want.stop) begin
            $error("stop_event: expected %0d, actual %0d", want.stop, out_stop_event);
            fail_count++;
          end
        end
      end
    end
    pending_words <= expected_targets.size();
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// Top of the velocity_frame_receiver_watchdog testbench: clock, reset, stimulus and verdict.
// Depends on vfrw_pkg, the block itself and vfrw_target_checker.
module testbench;
  import vfrw_pkg::*;

  localparam int RANDOM_WORDS    = 1250;
  localparam int PHASES          = 6;
  localparam int FRAME_BYTES     = WIN_DEPTH + 1;
  localparam int HOLD_OFF_CYCLES = 64;
  localparam int QUIET_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 8;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_write_en;
  logic [15:0]        cfg_write_data;
  logic               in_valid;
  logic               in_stall;
  logic               in_command;
  logic [7:0]         in_rx_byte;
  logic               in_chunk_end;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] out_left_target;
  logic signed [15:0] out_right_target;
  logic               out_frame_accepted;
  logic               out_stop_event;

  int unsigned fail_count;
  int unsigned pending_words;
  int unsigned words_checked;
  int unsigned frames_seen;
  int unsigned stops_seen;
  int unsigned words_sent   = 0;
  int unsigned quiet_cycles = 0;
  bit          calm         = 1'b0;
  bit          hold_off_req = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  velocity_frame_receiver_watchdog u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_write_en       (cfg_write_en),
    .cfg_write_data     (cfg_write_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_rx_byte         (in_rx_byte),
    .in_chunk_end       (in_chunk_end),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_left_target    (out_left_target),
    .out_right_target   (out_right_target),
    .out_frame_accepted (out_frame_accepted),
    .out_stop_event     (out_stop_event)
  );

  vfrw_target_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_write_en       (cfg_write_en),
    .cfg_write_data     (cfg_write_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_rx_byte         (in_rx_byte),
    .in_chunk_end       (in_chunk_end),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_left_target    (out_left_target),
    .out_right_target   (out_right_target),
    .out_frame_accepted (out_frame_accepted),
    .out_stop_event     (out_stop_event),
    .fail_count         (fail_count),
    .pending_words      (pending_words),
    .words_checked      (words_checked),
    .frames_seen        (frames_seen),
    .stops_seen         (stops_seen)
  );

  // Result side: random stalls, none while calm, and one long hold-off on request.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 25);
      end
    end
  end

  // End the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("velocity_frame_receiver_watchdog regression: fail");
      $finish;
    end
  end

  // Offers one word, with an occasional random gap in front of it, and waits until it is taken.
  task automatic send_word(input logic cmd, input logic [7:0] rx, input logic ce);
    int unsigned gap;
    if (!calm && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_rx_byte   <= rx;
    in_chunk_end <= ce;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // Sends a velocity frame; one byte may be corrupted and a chunk end may split it.
  task automatic send_frame(input logic [15:0] left, input logic [15:0] right,
                            input int bad_at, input int split_at, input logic last_ce);
    logic [7:0] frame [FRAME_BYTES];
    frame[0] = SYNC_FIRST;
    frame[1] = SYNC_SECOND;
    frame[2] = VEL_TYPE;
    frame[3] = VEL_LEN;
    frame[4] = left[7:0];
    frame[5] = left[15:8];
    frame[6] = right[7:0];
    frame[7] = right[15:8];
    frame[8] = VEL_TYPE ^ VEL_LEN ^ left[7:0] ^ left[15:8] ^ right[7:0] ^ right[15:8];
    if (bad_at >= 0) frame[bad_at] ^= 8'($urandom_range(1, 255));
    for (int k = 0; k < FRAME_BYTES; k++)
      send_word(CMD_BYTE, frame[k], (k == split_at) || (k == FRAME_BYTES - 1 && last_ce));
  endtask

  // Lowers valid and waits until every expected word has come out.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes the watchdog limit while the block is idle.
  task automatic write_limit(input logic [15:0] limit);
    drain_pipeline();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= limit;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  // One random slice of traffic: mostly frames, some tick runs, some line noise.
  task automatic random_burst(input logic [15:0] limit);
    int unsigned pick;
    int unsigned n;
    int          bad_at;
    int          split_at;
    pick = $urandom_range(99);
    if (pick < 60) begin
      bad_at   = ($urandom_range(7) == 0) ? int'($urandom_range(0, FRAME_BYTES - 1)) : -1;
      split_at = ($urandom_range(7) == 0) ? int'($urandom_range(0, FRAME_BYTES - 2)) : -1;
      send_frame(16'($urandom), 16'($urandom), bad_at, split_at, $urandom_range(3) == 0);
    end else if (pick < 85) begin
      // Runs long enough to expire small limits now and then.
      n = (limit < 16) ? $urandom_range(1, 2 * int'(limit) + 2) : $urandom_range(1, 6);
      repeat (n) send_word(CMD_TICK, 8'($urandom), 1'($urandom));
    end else begin
      n = $urandom_range(1, 3);
      repeat (n)
        send_word(CMD_BYTE, ($urandom_range(3) == 0) ? SYNC_FIRST : 8'($urandom),
                  $urandom_range(9) == 0);
    end
  endtask

  initial begin
    logic [15:0] limit;
    int unsigned stop_at;
    rst_n          <= 1'b0;
    cfg_write_en   <= 1'b0;
    cfg_write_data <= '0;
    in_valid       <= 1'b0;
    in_command     <= CMD_BYTE;
    in_rx_byte     <= '0;
    in_chunk_end   <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // A stray sync byte in front makes the full window slide once before the match.
    write_limit(16'd2);
    send_word(CMD_BYTE, SYNC_FIRST, 1'b0);
    send_frame(16'h8000, 16'h7FFF, -1, -1, 1'b0);
    // Ticks ignore the byte and chunk end; the second expires, the third is saturated.
    send_word(CMD_TICK, 8'hFF, 1'b1);
    send_word(CMD_TICK, 8'h00, 1'b0);
    send_word(CMD_TICK, 8'hA5, 1'b1);
    // Lowering the limit below the current count must not fire the watchdog.
    write_limit(16'hFFFF);
    repeat (3) send_word(CMD_TICK, 8'h00, 1'b0);
    write_limit(16'd1);
    send_word(CMD_TICK, 8'h00, 1'b0);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       limit = 16'd1;
        1:       limit = 16'hFFFF;
        2:       limit = 16'd3;
        3:       limit = 16'd12;
        4:       limit = 16'($urandom_range(2, 40));
        default: limit = WDOG_LIMIT_RST;
      endcase
      write_limit(limit);
      calm = (phase == 2);
      if (phase == 3) hold_off_req = 1'b1;
      stop_at = words_sent + RANDOM_WORDS / PHASES;
      while (words_sent < stop_at) random_burst(limit);
    end
    calm = 1'b0;

    drain_pipeline();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d words and checked %0d results: %0d frames accepted, %0d watchdog stops.",
             words_sent, words_checked, frames_seen, stops_seen);
    $display("Watchdog limits from 1 to 65535, one long receiver hold-off, one stall-free phase.");
    if (fail_count == 0 && pending_words == 0) begin
      $display("velocity_frame_receiver_watchdog regression: pass");
    end else begin
      $display("velocity_frame_receiver_watchdog regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/vfrw_pkg.sv
src/vfrw_window.sv
src/vfrw_watchdog.sv
src/velocity_frame_receiver_watchdog.sv
dv/vfrw_target_checker.sv
dv/testbench.sv
